// File: sv/clock_page_replacement_core_defines.svh
// assertion macros for the clock page replacement core
`ifndef CLOCK_PAGE_REPLACEMENT_CORE_DEFINES_SVH
`define CLOCK_PAGE_REPLACEMENT_CORE_DEFINES_SVH

`ifndef SYNTH
`define CPR_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define CPR_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define CPR_ASSERT_IMPL(label, ante, cons)
`define CPR_ASSERT_NEXT(label, ante, cons)
`endif

`endif

// File: sv/cpr_pkg.sv
// shared types and constants for the clock page replacement core
package cpr_pkg;

  localparam int MAX_FRAMES_DEF = 8;
  localparam int FIU_W          = 4;
  localparam int PAGE_W         = 8;
  localparam int IDX_W          = 3;
  localparam int FAULT_W        = 16;

  localparam logic [FIU_W-1:0] FIU_RESET = 4'd3;

  typedef struct packed {
    logic [PAGE_W-1:0] page_number;
  } cpr_in_t;

  typedef struct packed {
    logic               hit;
    logic [IDX_W-1:0]   frame_index;
    logic               evicted_valid;
    logic [PAGE_W-1:0]  evicted_page;
    logic [FAULT_W-1:0] fault_total;
  } cpr_out_t;

endpackage

// File: sv/cpr_chan_if.sv
// valid/ready channel carrying one payload per transfer
interface cpr_chan_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: sv/clock_page_replacement_core.sv
// clock (second chance) page replacement core
//
//   channel  | dir | payload                                        | handshake
//   in_chan  | in  | page_number                                    | valid/ready
//   out_chan | out | hit, frame_index, evicted_valid, evicted_page,  | valid/ready
//            |     | fault_total                                    |
//   cfg      | in  | frames_in_use (cfg_wdata)                      | cfg_we
//
// one reference at a time: an accept step, then one frame compared per cycle
// (stopping early on a hit), then on a miss one hand step per cycle and a
// fill step; all set by the single page memory read port and the shared
// comparator
// reset clears frames, use bits, hand, fault count and sets frames_in_use to 3
// the finished result sits in an output register; the core stalls only when
// a new result is ready while the previous one has not been taken
module clock_page_replacement_core #(
  parameter int MAX_FRAMES = cpr_pkg::MAX_FRAMES_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_we,
  input  logic [cpr_pkg::FIU_W-1:0]  cfg_wdata,
  cpr_chan_if.sink                   in_chan,
  cpr_chan_if.source                 out_chan
);
  import cpr_pkg::*;

  localparam int FW = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
  localparam int NW = $clog2(MAX_FRAMES + 1);

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_SWEEP, S_FILL} state_t;

  state_t                  state_r;
  logic [FIU_W-1:0]        fiu_r;
  logic [PAGE_W-1:0]       page_r;
  logic [FW-1:0]           k_r;
  logic [FW-1:0]           hand_r;
  logic [MAX_FRAMES-1:0]   valid_r;
  logic [MAX_FRAMES-1:0]   use_r;
  logic [FAULT_W-1:0]      fault_r;
  logic                    out_valid_r;
  cpr_out_t                out_data_r;
  logic [PAGE_W-1:0]       pages_mem [MAX_FRAMES];
  logic [PAGE_W-1:0]       rd_data_r;

  logic [NW-1:0]           n_c;
  logic [NW-1:0]           last_c;
  logic [NW-1:0]           hand_inc_c;
  logic [FW-1:0]           hand_adv_c;
  logic [FW-1:0]           rd_addr_c;
  logic [FAULT_W-1:0]      fault_nxt;
  logic                    match_c;
  logic                    out_busy_c;
  logic                    mem_we_c;
  logic                    res_fire_c;

  always_comb begin
    if (fiu_r == '0) begin
      n_c = NW'(1);
    end else if (int'(fiu_r) > MAX_FRAMES) begin
      n_c = NW'(MAX_FRAMES);
    end else begin
      n_c = NW'(fiu_r);
    end
  end

  assign last_c     = n_c - NW'(1);
  assign hand_inc_c = NW'(hand_r) + NW'(1);
  assign hand_adv_c = (hand_inc_c >= n_c) ? '0 : FW'(hand_inc_c);
  assign match_c    = valid_r[k_r] && (rd_data_r == page_r);
  assign out_busy_c = out_valid_r && !out_chan.ready;
  assign fault_nxt  = (fault_r == '1) ? fault_r : fault_r + FAULT_W'(1);
  assign mem_we_c   = (state_r == S_FILL) && !out_busy_c;
  assign res_fire_c = !out_busy_c &&
                      (((state_r == S_SCAN) && match_c) || (state_r == S_FILL));

  always_comb begin
    unique case (state_r)
      S_IDLE:  rd_addr_c = '0;
      S_SCAN:  rd_addr_c = match_c ? k_r : k_r + FW'(1);
      S_SWEEP: rd_addr_c = hand_r;
      S_FILL:  rd_addr_c = hand_r;
      default: rd_addr_c = '0;
    endcase
  end

  assign in_chan.ready  = (state_r == S_IDLE);
  assign out_chan.valid = out_valid_r;
  assign out_chan.data  = out_data_r;

  // page store
  always_ff @(posedge clk) begin
    rd_data_r <= pages_mem[rd_addr_c];
    if (mem_we_c) begin
      pages_mem[hand_r] <= page_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      fiu_r       <= FIU_RESET;
      hand_r      <= '0;
      valid_r     <= '0;
      use_r       <= '0;
      fault_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        fiu_r <= cfg_wdata;
      end
      if (res_fire_c) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_chan.valid) begin
            page_r  <= in_chan.data.page_number;
            k_r     <= '0;
            state_r <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (match_c) begin
            if (!out_busy_c) begin
              use_r[k_r]               <= 1'b1;
              out_data_r.hit           <= 1'b1;
              out_data_r.frame_index   <= IDX_W'(k_r);
              out_data_r.evicted_valid <= 1'b0;
              out_data_r.evicted_page  <= '0;
              out_data_r.fault_total   <= fault_r;
              state_r                  <= S_IDLE;
            end
          end else if (NW'(k_r) == last_c) begin
            // hand may sit past the frames in use after a config change
            if (NW'(hand_r) >= n_c) begin
              hand_r <= '0;
            end
            state_r <= S_SWEEP;
          end else begin
            k_r <= k_r + FW'(1);
          end
        end
        S_SWEEP: begin
          if (use_r[hand_r]) begin
            use_r[hand_r] <= 1'b0;
            hand_r        <= hand_adv_c;
          end else begin
            state_r <= S_FILL;
          end
        end
        S_FILL: begin
          if (!out_busy_c) begin
            valid_r[hand_r]          <= 1'b1;
            use_r[hand_r]            <= 1'b1;
            hand_r                   <= hand_adv_c;
            fault_r                  <= fault_nxt;
            out_data_r.hit           <= 1'b0;
            out_data_r.frame_index   <= IDX_W'(hand_r);
            out_data_r.evicted_valid <= valid_r[hand_r];
            out_data_r.evicted_page  <= valid_r[hand_r] ? rd_data_r : '0;
            out_data_r.fault_total   <= fault_nxt;
            state_r                  <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  `include "clock_page_replacement_core_defines.svh"

  `CPR_ASSERT_NEXT(a_busy_after_accept, in_chan.valid && in_chan.ready, !in_chan.ready)
  `CPR_ASSERT_IMPL(a_hit_no_evict, out_valid_r && out_data_r.hit, !out_data_r.evicted_valid && (out_data_r.evicted_page == '0))
  `CPR_ASSERT_NEXT(a_fault_monotonic, 1'b1, fault_r >= $past(fault_r))
  `CPR_ASSERT_IMPL(a_sweep_hand_in_range, state_r == S_SWEEP, NW'(hand_r) < n_c)

endmodule
